@@ hw/rtl/sbpr_pkg.sv @@
// types and constants shared by the buffer pool ring logic
package sbpr_pkg;

    localparam int unsigned OP_W      = 3;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned BUF_W     = 64;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 4;
    localparam int unsigned MIN_ORDER = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_ORDER    = 2'd1;

    localparam logic [CFG_W-1:0] RING_ORDER_RESET = 4'd3;

    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE     = 3'd0,
        OP_RELEASE     = 3'd1,
        OP_REFILL      = 3'd2,
        OP_DRAIN       = 3'd3,
        OP_FREE_RETURN = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_FULL       = 3'd2,
        ST_NOT_MASTER = 3'd3,
        ST_DRAINED    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_REFILL,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/shared_buffer_pool_rings.sv @@
// shared buffer pool: alloc ring and free ring of 64-bit descriptors in two memories
//
// The pool keeps two rings of buffer descriptors, each held in its own single-port-per-direction
// synchronous memory of 2^MAX_ORDER entries, with ring_order (clamped to 3..MAX_ORDER) selecting
// how many entries are in use. Each item runs on its own: it is taken in one cycle and executed
// in the next. Release, free_return, rejected operations, a drain of an empty pool and unused
// codes finish in the execute state. Acquire and drain that pop a descriptor add the pop state
// for the registered memory read. Refill moves one descriptor per cycle through the free ring's
// read port and the alloc ring's write port until the free ring is empty or the alloc ring is
// full. A new item is taken while a finished result still waits in the output register; the
// next result then waits until that register is emptied. Neither items nor register writes
// are taken while reset is held. The rings come up with unknown contents and are never cleared;
// the four ring counters reset to zero.
module shared_buffer_pool_rings #(
    parameter int unsigned MAX_ORDER = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sbpr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sbpr_pkg::CFG_W-1:0]     i_cfg_data,
    // operation items
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [sbpr_pkg::OP_W-1:0]      i_operation,
    input  logic [sbpr_pkg::BUF_W-1:0]     i_buffer,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [sbpr_pkg::STATUS_W-1:0]  o_status,
    output logic [sbpr_pkg::BUF_W-1:0]     o_buffer_out,
    output logic [MAX_ORDER:0]             o_moved_count
);
    import sbpr_pkg::*;

    localparam int unsigned AW    = MAX_ORDER;          // ring index width
    localparam int unsigned CW    = MAX_ORDER + 1;      // free-running counter width
    localparam int unsigned DEPTH = 1 << MAX_ORDER;
    localparam int unsigned OW    = $clog2(MAX_ORDER + 1);

    // ring storage, contents undefined until written
    logic [BUF_W-1:0] alloc_mem [DEPTH];
    logic [BUF_W-1:0] free_mem  [DEPTH];

    // configuration
    logic             r_master;
    logic [CFG_W-1:0] r_ring_order;

    // control state
    t_state  r_state, n_state;
    logic [CW-1:0] r_alloc_enq, n_alloc_enq;
    logic [CW-1:0] r_alloc_deq, n_alloc_deq;
    logic [CW-1:0] r_free_enq,  n_free_enq;
    logic [CW-1:0] r_free_deq,  n_free_deq;
    logic          r_pend,      n_pend;         // refill write still to land in alloc ring
    logic [CW-1:0] r_moved,     n_moved;
    logic          r_pop_free,  n_pop_free;     // pop came from the free ring
    t_status       r_pop_status, n_pop_status;

    // captured item
    t_op              r_op;
    logic [BUF_W-1:0] r_buf;
    logic [AW-1:0]    r_wr_idx, n_wr_idx;

    // pending result when the output register is still occupied
    t_status          r_res_status;
    logic [BUF_W-1:0] r_res_buf;
    logic [CW-1:0]    r_res_moved;

    // output register
    logic             r_out_valid;
    t_status          r_out_status;
    logic [BUF_W-1:0] r_out_buf;
    logic [CW-1:0]    r_out_moved;

    // memory ports
    logic             alloc_we, alloc_re, free_we, free_re;
    logic [AW-1:0]    alloc_wa, alloc_ra, free_wa, free_ra;
    logic [BUF_W-1:0] alloc_wd, free_wd;
    logic [BUF_W-1:0] r_alloc_rd, r_free_rd;

    // ring geometry from the clamped order
    logic [OW-1:0] ord_c;
    logic [AW-1:0] idx_mask;
    logic [CW-1:0] ring_len;
    logic [CW-1:0] alloc_occ, free_occ;
    logic          alloc_empty, alloc_full, free_empty, free_full;

    logic             in_acc, slot_free, fin, out_load;
    t_status          res_status;
    logic [BUF_W-1:0] res_buf;
    logic [CW-1:0]    res_moved;

    always_comb begin
        if (int'(r_ring_order) < int'(MIN_ORDER)) begin
            ord_c = OW'(MIN_ORDER);
        end else if (int'(r_ring_order) > int'(MAX_ORDER)) begin
            ord_c = OW'(MAX_ORDER);
        end else begin
            ord_c = OW'(r_ring_order);
        end
    end

    assign ring_len    = CW'(1) << ord_c;
    assign idx_mask    = AW'(ring_len - CW'(1));
    assign alloc_occ   = r_alloc_enq - r_alloc_deq;
    assign free_occ    = r_free_enq - r_free_deq;
    assign alloc_empty = (alloc_occ == '0);
    assign free_empty  = (free_occ == '0);
    assign alloc_full  = (alloc_occ >= ring_len);
    assign free_full   = (free_occ >= ring_len);

    // nothing is taken while reset is held
    assign o_cfg_ready = i_rst_n;
    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master     <= 1'b0;
            r_ring_order <= RING_ORDER_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MASTER_ENABLE: r_master     <= i_cfg_data[0];
                CFG_RING_ORDER:    r_ring_order <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state and memory access decode
    always_comb begin
        n_state      = r_state;
        n_alloc_enq  = r_alloc_enq;
        n_alloc_deq  = r_alloc_deq;
        n_free_enq   = r_free_enq;
        n_free_deq   = r_free_deq;
        n_pend       = 1'b0;
        n_moved      = r_moved;
        n_pop_free   = r_pop_free;
        n_pop_status = r_pop_status;
        n_wr_idx     = r_wr_idx;
        alloc_we     = 1'b0;
        alloc_wa     = r_wr_idx;
        alloc_wd     = r_free_rd;
        alloc_re     = 1'b0;
        alloc_ra     = r_alloc_deq[AW-1:0] & idx_mask;
        free_we      = 1'b0;
        free_wa      = r_free_enq[AW-1:0] & idx_mask;
        free_wd      = r_buf;
        free_re      = 1'b0;
        free_ra      = r_free_deq[AW-1:0] & idx_mask;
        fin          = 1'b0;
        res_status   = ST_OK;
        res_buf      = '0;
        res_moved    = '0;

        // moved descriptor read last cycle lands in the alloc ring
        if (r_pend) begin
            alloc_we = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_ACQUIRE: begin
                        if (!r_master) begin
                            fin        = 1'b1;
                            res_status = ST_NOT_MASTER;
                        end else if (alloc_empty) begin
                            fin        = 1'b1;
                            res_status = ST_EMPTY;
                        end else begin
                            alloc_re     = 1'b1;
                            n_alloc_deq  = r_alloc_deq + CW'(1);
                            n_pop_free   = 1'b0;
                            n_pop_status = ST_OK;
                            n_state      = S_POP;
                        end
                    end
                    OP_RELEASE: begin
                        fin = 1'b1;
                        if (alloc_full) begin
                            res_status = ST_FULL;
                        end else begin
                            alloc_we    = 1'b1;
                            alloc_wa    = r_alloc_enq[AW-1:0] & idx_mask;
                            alloc_wd    = r_buf;
                            n_alloc_enq = r_alloc_enq + CW'(1);
                        end
                    end
                    OP_REFILL: begin
                        n_moved = '0;
                        n_state = S_REFILL;
                    end
                    OP_DRAIN: begin
                        if (!free_empty) begin
                            free_re      = 1'b1;
                            n_free_deq   = r_free_deq + CW'(1);
                            n_pop_free   = 1'b1;
                            n_pop_status = ST_DRAINED;
                            n_state      = S_POP;
                        end else if (!alloc_empty) begin
                            alloc_re     = 1'b1;
                            n_alloc_deq  = r_alloc_deq + CW'(1);
                            n_pop_free   = 1'b0;
                            n_pop_status = ST_DRAINED;
                            n_state      = S_POP;
                        end else begin
                            // pool fully drained
                            fin = 1'b1;
                        end
                    end
                    OP_FREE_RETURN: begin
                        fin = 1'b1;
                        if (free_full) begin
                            res_status = ST_FULL;
                        end else begin
                            free_we    = 1'b1;
                            n_free_enq = r_free_enq + CW'(1);
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_POP: begin
                fin        = 1'b1;
                res_status = r_pop_status;
                res_buf    = r_pop_free ? r_free_rd : r_alloc_rd;
            end
            S_REFILL: begin
                // counters already count the descriptor in flight
                if (!free_empty && !alloc_full) begin
                    free_re     = 1'b1;
                    n_free_deq  = r_free_deq + CW'(1);
                    n_wr_idx    = r_alloc_enq[AW-1:0] & idx_mask;
                    n_alloc_enq = r_alloc_enq + CW'(1);
                    n_moved     = r_moved + CW'(1);
                    n_pend      = 1'b1;
                end else begin
                    fin       = 1'b1;
                    res_moved = r_moved;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = slot_free ? S_IDLE : S_DONE;
        end
    end

    assign out_load = slot_free && (fin || (r_state == S_DONE));

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_alloc_enq  <= '0;
            r_alloc_deq  <= '0;
            r_free_enq   <= '0;
            r_free_deq   <= '0;
            r_pend       <= 1'b0;
            r_moved      <= '0;
            r_pop_free   <= 1'b0;
            r_pop_status <= ST_OK;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_alloc_enq  <= n_alloc_enq;
            r_alloc_deq  <= n_alloc_deq;
            r_free_enq   <= n_free_enq;
            r_free_deq   <= n_free_deq;
            r_pend       <= n_pend;
            r_moved      <= n_moved;
            r_pop_free   <= n_pop_free;
            r_pop_status <= n_pop_status;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_wr_idx <= n_wr_idx;
        if (in_acc) begin
            r_op  <= t_op'(i_operation);
            r_buf <= i_buffer;
        end
        if (fin) begin
            r_res_status <= res_status;
            r_res_buf    <= res_buf;
            r_res_moved  <= res_moved;
        end
        if (out_load) begin
            if (r_state == S_DONE) begin
                r_out_status <= r_res_status;
                r_out_buf    <= r_res_buf;
                r_out_moved  <= r_res_moved;
            end else begin
                r_out_status <= res_status;
                r_out_buf    <= res_buf;
                r_out_moved  <= res_moved;
            end
        end
    end

    // alloc ring memory
    always_ff @(posedge i_clk) begin
        if (alloc_we) begin
            alloc_mem[alloc_wa] <= alloc_wd;
        end
        if (alloc_re) begin
            r_alloc_rd <= alloc_mem[alloc_ra];
        end
    end

    // free ring memory
    always_ff @(posedge i_clk) begin
        if (free_we) begin
            free_mem[free_wa] <= free_wd;
        end
        if (free_re) begin
            r_free_rd <= free_mem[free_ra];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_buffer_out  = r_out_buf;
    assign o_moved_count = r_out_moved;

    // a ring never holds more than its memory depth
    a_alloc_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alloc_occ <= CW'(DEPTH))
        else $error("alloc ring occupancy beyond depth");

    a_free_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        free_occ <= CW'(DEPTH))
        else $error("free ring occupancy beyond depth");

    // a moved descriptor lands only while refill is still walking
    a_pend_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_REFILL))
        else $error("refill write outside refill");

    // counters stay put while waiting for an item
    a_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> ($stable(r_alloc_enq) && $stable(r_alloc_deq)
                                 && $stable(r_free_enq) && $stable(r_free_deq)))
        else $error("ring counter moved while idle");

    // a refill stops only when the free ring is empty or the alloc ring is full
    a_refill_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_REFILL) && fin) |-> (free_empty || alloc_full))
        else $error("refill stopped early");

endmodule

@@ dv/shared_buffer_pool_rings_tb.sv @@
// self-checking testbench for the shared buffer pool with alloc and free rings
module shared_buffer_pool_rings_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbpr_pkg::*;

    localparam int MAX_ORDER  = 10;
    localparam int RING_DEPTH = 1 << MAX_ORDER;

    // ring selectors for the shadow pool
    localparam int RING_ALLOC = 0;
    localparam int RING_FREE  = 1;

    // operation codes with no function, and register indexes with no register
    localparam logic [OP_W-1:0]      OP_CODE_SPARE = 3'd5;
    localparam logic [OP_W-1:0]      OP_CODE_LAST  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B   = 2'd3;

    localparam int N_PHASES    = 12;
    localparam int HOLD_PHASE  = 2;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 20;
    localparam int TIMEOUT_NS  = 10_000_000;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [BUF_W-1:0] buffer;
    } pool_req_t;

    typedef struct {
        logic [OP_W-1:0]    op;
        t_status            status;
        logic [BUF_W-1:0]   buffer_out;
        logic [MAX_ORDER:0] moved;
    } pool_reply_t;

    // dut connections, all driven from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic [OP_W-1:0]      i_operation = '0;
    logic [BUF_W-1:0]     i_buffer    = '0;
    logic                 i_out_ready = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [BUF_W-1:0]     o_buffer_out;
    logic [MAX_ORDER:0]   o_moved_count;

    shared_buffer_pool_rings #(
        .MAX_ORDER(MAX_ORDER)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_buffer     (i_buffer),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_buffer_out (o_buffer_out),
        .o_moved_count(o_moved_count)
    );

    // shadow pool: ring memories, which slots were ever written, and the counters
    logic [BUF_W-1:0]   ring_mem     [2][RING_DEPTH];
    bit                 ring_written [2][RING_DEPTH];
    logic [MAX_ORDER:0] enq_cnt      [2] = '{'0, '0};
    logic [MAX_ORDER:0] deq_cnt      [2] = '{'0, '0};
    logic               master_q = 1'b0;
    logic [CFG_W-1:0]   order_q  = RING_ORDER_RESET;

    // items waiting for the driver, and replies the pool still owes
    pool_req_t   op_backlog[$];
    pool_reply_t expected_replies[$];

    int  items_queued   = 0;
    int  replies_popped = 0;
    int  error_count    = 0;
    bit  in_taken       = 1'b0;
    int  send_gap       = 0;
    int  recv_gap       = 0;
    int  send_idle_pct  = 30;
    int  recv_idle_pct  = 30;
    int  hold_requests  = 0;
    int  hold_started   = 0;
    int  hold_left      = 0;
    pool_req_t drv_req;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the pool hangs
    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------- shadow pool

    // ring_order below the minimum acts as the minimum, above the maximum as the maximum
    function automatic int eff_order(logic [CFG_W-1:0] ord);
        if (ord < MIN_ORDER) return MIN_ORDER;
        if (ord > MAX_ORDER) return MAX_ORDER;
        return int'(ord);
    endfunction

    function automatic int ring_entries();
        return 1 << eff_order(order_q);
    endfunction

    // counters run free over MAX_ORDER+1 bits, so the difference wraps the same way
    function automatic int occupancy(int r);
        logic [MAX_ORDER:0] d;
        d = enq_cnt[r] - deq_cnt[r];
        return int'(d);
    endfunction

    function automatic bit ring_full(int r);
        return occupancy(r) >= ring_entries();
    endfunction

    function automatic int slot_of(logic [MAX_ORDER:0] c);
        return int'(c) & (ring_entries() - 1) & (RING_DEPTH - 1);
    endfunction

    function automatic logic [BUF_W-1:0] ring_pop(int r);
        logic [BUF_W-1:0] v;
        v = ring_mem[r][slot_of(deq_cnt[r])];
        deq_cnt[r] = deq_cnt[r] + 1'b1;
        return v;
    endfunction

    function automatic void ring_push(int r, logic [BUF_W-1:0] v);
        ring_mem[r][slot_of(enq_cnt[r])] = v;
        ring_written[r][slot_of(enq_cnt[r])] = 1'b1;
        enq_cnt[r] = enq_cnt[r] + 1'b1;
    endfunction

    // executes one operation on the shadow pool and returns the reply it must give
    function automatic pool_reply_t pool_execute(logic [OP_W-1:0] op, logic [BUF_W-1:0] buffer);
        pool_reply_t r;
        r.op         = op;
        r.status     = ST_OK;
        r.buffer_out = '0;
        r.moved      = '0;
        case (op)
            OP_ACQUIRE: begin
                // master check wins over the empty check
                if (!master_q) r.status = ST_NOT_MASTER;
                else if (occupancy(RING_ALLOC) == 0) r.status = ST_EMPTY;
                else r.buffer_out = ring_pop(RING_ALLOC);
            end
            OP_RELEASE: begin
                if (ring_full(RING_ALLOC)) r.status = ST_FULL;
                else ring_push(RING_ALLOC, buffer);
            end
            OP_REFILL: begin
                while (occupancy(RING_FREE) != 0 && !ring_full(RING_ALLOC)) begin
                    ring_push(RING_ALLOC, ring_pop(RING_FREE));
                    r.moved = r.moved + 1'b1;
                end
            end
            OP_DRAIN: begin
                // free ring first; both empty means fully drained, status ok
                if (occupancy(RING_FREE) != 0) begin
                    r.buffer_out = ring_pop(RING_FREE);
                    r.status     = ST_DRAINED;
                end else if (occupancy(RING_ALLOC) != 0) begin
                    r.buffer_out = ring_pop(RING_ALLOC);
                    r.status     = ST_DRAINED;
                end
            end
            OP_FREE_RETURN: begin
                if (ring_full(RING_FREE)) r.status = ST_FULL;
                else ring_push(RING_FREE, buffer);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // a new order is only taken if every live entry then maps onto a slot written before
    function automatic bit order_safe(logic [CFG_W-1:0] ord);
        int                 mask;
        logic [MAX_ORDER:0] c;
        mask = (1 << eff_order(ord)) - 1;
        for (int r = 0; r < 2; r++) begin
            c = deq_cnt[r];
            for (int k = 0; k < occupancy(r); k++) begin
                if (!ring_written[r][int'(c) & mask]) return 1'b0;
                c = c + 1'b1;
            end
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(9) == 0) return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(2))
            0: return 0;
            1: return 25;
            default: return 60;
        endcase
    endfunction

    // small orders most of the time, the clamped ranges and the maximum now and then
    function automatic logic [CFG_W-1:0] pick_order();
        int r;
        r = $urandom_range(99);
        if (r < 50) return 4'($urandom_range(5, 3));
        if (r < 62) return 4'($urandom_range(2, 0));
        if (r < 74) return 4'($urandom_range(9, 6));
        if (r < 86) return 4'(MAX_ORDER);
        return 4'($urandom_range(15, 11));
    endfunction

    function automatic logic [BUF_W-1:0] random_buffer();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // push_pct steers the rings toward full or toward empty
    function automatic pool_req_t random_request(int push_pct);
        pool_req_t q;
        int        r;
        r = $urandom_range(99);
        if (r < 3) q.op = 3'($urandom_range(OP_CODE_LAST, OP_CODE_SPARE));
        else if (r < 10) q.op = OP_REFILL;
        else if ($urandom_range(99) < push_pct)
            q.op = $urandom_range(1) ? OP_RELEASE : OP_FREE_RETURN;
        else q.op = ($urandom_range(99) < 60) ? OP_ACQUIRE : OP_DRAIN;
        q.buffer = random_buffer();
        return q;
    endfunction

    task automatic queue_req(input logic [OP_W-1:0] op, input logic [BUF_W-1:0] buffer);
        pool_req_t q;
        q.op     = op;
        q.buffer = buffer;
        op_backlog.push_back(q);
        items_queued++;
    endtask

    // sender pause: returns once every queued item has its reply checked
    task automatic wait_idle();
        do @(negedge i_clk);
        while (replies_popped != items_queued);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        if (idx == CFG_MASTER_ENABLE) master_q = val[0];
        else if (idx == CFG_RING_ORDER) order_q = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // empties both rings, one extra drain to see the fully drained reply
    task automatic drain_pool();
        repeat (occupancy(RING_ALLOC) + occupancy(RING_FREE) + 1)
            queue_req(OP_DRAIN, random_buffer());
        wait_idle();
    endtask

    // only called with the pool idle
    task automatic set_pool_config(input bit master, input logic [CFG_W-1:0] ord);
        if (!order_safe(ord)) drain_pool();
        write_reg(CFG_MASTER_ENABLE, {3'($urandom_range(7)), master});
        write_reg(CFG_RING_ORDER, ord);
    endtask

    // ---------------------------------------------------------------- driver

    // a new item goes up only once the previous one was taken at the last rising edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (op_backlog.size() > 0) begin
                drv_req = op_backlog.pop_front();
                i_in_valid  <= 1'b1;
                i_operation <= drv_req.op;
                i_buffer    <= drv_req.buffer;
                if ($urandom_range(99) < send_idle_pct) send_gap = gap_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: long hold on request, otherwise random stalls
    always @(negedge i_clk) begin
        if (hold_started != hold_requests) begin
            hold_started = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(99) < recv_idle_pct) recv_gap = gap_len();
        end
    end

    // ---------------------------------------------------------------- monitor

    function automatic void note_failure(string msg);
        error_count++;
        if (error_count <= 10) $display("%s", msg);
    endfunction

    always @(posedge i_clk) begin : monitor
        pool_reply_t want;
        in_taken = i_rst_n && i_in_valid && o_in_ready;
        // compare before adding this edge's item, its reply cannot be out yet
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_replies.size() == 0) begin
                note_failure($sformatf("%0t: reply with none pending: status %0d buf %h moved %0d",
                                       $realtime, o_status, o_buffer_out, o_moved_count));
            end else begin
                want = expected_replies.pop_front();
                replies_popped++;
                if (o_status !== want.status || o_buffer_out !== want.buffer_out ||
                    o_moved_count !== want.moved) begin
                    note_failure($sformatf(
                        "%0t: op %0d expected status %0d buf %h moved %0d, got %0d %h %0d",
                        $realtime, want.op, want.status, want.buffer_out, want.moved,
                        o_status, o_buffer_out, o_moved_count));
                end
            end
        end
        if (in_taken) expected_replies.push_back(pool_execute(i_operation, i_buffer));
    end

    // ---------------------------------------------------------------- test sequence

    initial begin
        int push_pct;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: not master, smallest rings
        queue_req(OP_ACQUIRE, '0);            // not master
        queue_req(OP_DRAIN, '1);              // nothing to drain
        queue_req(OP_REFILL, '0);             // nothing to move
        queue_req(OP_CODE_LAST, '1);          // unused code
        queue_req(OP_RELEASE, '0);
        queue_req(OP_RELEASE, '1);
        queue_req(OP_FREE_RETURN, 64'h8000_0000);
        queue_req(OP_DRAIN, '0);              // free ring goes first
        queue_req(OP_DRAIN, '0);
        queue_req(OP_DRAIN, '0);
        queue_req(OP_DRAIN, '0);              // both empty again
        wait_idle();

        // writes to the unused indexes must leave the pool alone
        write_reg(CFG_SPARE_A, 4'($urandom));
        write_reg(CFG_SPARE_B, 4'hF);

        // master with an order below range, acting as 8 entries
        set_pool_config(1'b1, 4'd0);
        queue_req(OP_ACQUIRE, '0);            // alloc ring empty
        repeat (9) queue_req(OP_FREE_RETURN, random_buffer());   // last one full
        queue_req(OP_RELEASE, random_buffer());
        queue_req(OP_RELEASE, random_buffer());
        queue_req(OP_REFILL, '0);             // stops on a full alloc ring
        queue_req(OP_RELEASE, random_buffer());  // full
        queue_req(OP_ACQUIRE, '0);
        wait_idle();

        // random phases, each with its own config, mix and idling
        for (int ph = 0; ph < N_PHASES; ph++) begin
            send_idle_pct = pick_idle();
            recv_idle_pct = pick_idle();
            set_pool_config($urandom_range(99) < 80, pick_order());
            case ($urandom_range(2))
                0: push_pct = 30;
                1: push_pct = 50;
                default: push_pct = 70;
            endcase
            // long receiver hold while the backlog keeps offering items
            if (ph == HOLD_PHASE) begin
                send_idle_pct = 0;
                hold_requests++;
            end
            repeat ($urandom_range(90, 40)) begin
                op_backlog.push_back(random_request(push_pct));
                items_queued++;
            end
            wait_idle();
        end

        // largest rings: fill the free ring past full, then one refill moves all of it
        send_idle_pct = 10;
        recv_idle_pct = 10;
        drain_pool();
        set_pool_config(1'b1, 4'd15);
        repeat (RING_DEPTH + 2) queue_req(OP_FREE_RETURN, random_buffer());
        queue_req(OP_REFILL, '0);
        queue_req(OP_RELEASE, random_buffer());
        queue_req(OP_FREE_RETURN, random_buffer());
        queue_req(OP_ACQUIRE, '0);
        wait_idle();

        // shrink back to the smallest order with the alloc ring still loaded
        set_pool_config(1'b1, 4'd3);
        queue_req(OP_RELEASE, random_buffer());
        queue_req(OP_FREE_RETURN, random_buffer());
        repeat (3) queue_req(OP_ACQUIRE, '0);
        repeat (3) queue_req(OP_DRAIN, '0);
        queue_req(OP_REFILL, '0);
        wait_idle();

        repeat (SETTLE) @(posedge i_clk);
        if (error_count == 0 && expected_replies.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
